// ----- sv/rrpt_pkg.sv -----
// Package for the round-robin process table.
// Holds the command codes, register map, the internal command and result types and
// the shared constants. It has no dependencies.
package rrpt_pkg;

	// Default number of process slots
	localparam int unsigned SLOTS_DEFAULT = 16;

	// Field widths
	localparam int unsigned ID_W    = 16;
	localparam int unsigned WORK_W  = 16;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned QUANT_W = 8;

	// Register port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// Register indexes
	localparam logic REG_TIME_QUANTUM = 1'b0;

	// Reset values and defaults
	localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd4;
	localparam logic [ID_W-1:0]    ID_RESET      = 16'd1;
	localparam logic [WORK_W-1:0]  DEFAULT_BURST = 16'd5;

	// Command codes
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_TICK  = 2'd1,
		OP_KILL  = 2'd2,
		OP_COUNT = 2'd3
	} op_t;

	// Command presented to the slot table
	typedef struct packed {
		logic              fire;
		op_t               opcode;
		logic [WORK_W-1:0] burst;
		logic [ID_W-1:0]   kill_id;
	} cmd_t;

	// Result of one command
	typedef struct packed {
		logic [ID_W-1:0]    new_id;
		logic               status;
		logic [COUNT_W-1:0] active_count;
	} res_t;

endpackage

// ----- sv/rrpt_cfg.sv -----
// Configuration register block of the round-robin process table.
// Holds the time quantum behind an APB-style port; depends on rrpt_pkg.
module rrpt_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rrpt_pkg::PADDR_W-1:0]        paddr,
	input  logic [rrpt_pkg::PDATA_W-1:0]        pwdata,
	output logic [rrpt_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	output logic [rrpt_pkg::QUANT_W-1:0]        quantum
);

	logic [rrpt_pkg::QUANT_W-1:0] quantum_q;
	logic                         sel_quantum;

	// Decode the word index from the byte address
	assign sel_quantum = (paddr[2] == rrpt_pkg::REG_TIME_QUANTUM);
	assign pready      = 1'b1;

	// Write the quantum on the access phase of a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= rrpt_pkg::QUANTUM_RESET;
		end else if (psel && penable && pwrite && pready && sel_quantum) begin
			quantum_q <= pwdata[rrpt_pkg::QUANT_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (sel_quantum) begin
			prdata[rrpt_pkg::QUANT_W-1:0] = quantum_q;
		end
	end

	assign quantum = quantum_q;

endmodule

// ----- sv/rrpt_table.sv -----
// Process slot table: used flags, identifiers, remaining work and the id counter.
// Applies one command per cycle and forms its result; depends on rrpt_pkg.
module rrpt_table #(
	parameter int unsigned SLOTS = rrpt_pkg::SLOTS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrpt_pkg::cmd_t                cmd,
	input  logic [rrpt_pkg::QUANT_W-1:0]  quantum,
	output rrpt_pkg::res_t                res
);

	logic [SLOTS-1:0]                used_q, used_d;
	logic [rrpt_pkg::ID_W-1:0]       id_q  [SLOTS];
	logic [rrpt_pkg::ID_W-1:0]       id_d  [SLOTS];
	logic [rrpt_pkg::WORK_W-1:0]     rem_q [SLOTS];
	logic [rrpt_pkg::WORK_W-1:0]     rem_d [SLOTS];
	logic [rrpt_pkg::ID_W-1:0]       ctr_q, ctr_d;

	logic [SLOTS-1:0]                free_vec, free_oh;
	logic [SLOTS-1:0]                match_vec, kill_oh;
	logic                            full;
	logic [rrpt_pkg::WORK_W-1:0]     burst_val;
	logic [rrpt_pkg::WORK_W-1:0]     quant_w;

	// Lowest free slot and lowest matching slot, as one-hot vectors
	always_comb begin
		free_vec = ~used_q;
		free_oh  = free_vec & (~free_vec + SLOTS'(1));
		full     = ~|free_vec;
		for (int i = 0; i < SLOTS; i++) begin
			match_vec[i] = used_q[i] && (id_q[i] == cmd.kill_id);
		end
		kill_oh = match_vec & (~match_vec + SLOTS'(1));
	end

	// Non-positive burst takes the default
	assign burst_val = (!cmd.burst[rrpt_pkg::WORK_W-1] && (cmd.burst != '0)) ?
		cmd.burst : rrpt_pkg::DEFAULT_BURST;
	assign quant_w   = {{(rrpt_pkg::WORK_W-rrpt_pkg::QUANT_W){1'b0}}, quantum};

	// Next state and result, then count used slots after the command
	always_comb begin
		used_d       = used_q;
		ctr_d        = ctr_q;
		id_d         = id_q;
		rem_d        = rem_q;
		res.new_id   = '0;
		res.status   = 1'b0;
		if (cmd.fire) begin
			unique case (cmd.opcode)
				rrpt_pkg::OP_ADD: begin
					if (full) begin
						res.status = 1'b1;
					end else begin
						for (int i = 0; i < SLOTS; i++) begin
							if (free_oh[i]) begin
								used_d[i] = 1'b1;
								id_d[i]   = ctr_q;
								rem_d[i]  = burst_val;
							end
						end
						res.new_id = ctr_q;
						ctr_d      = ctr_q + rrpt_pkg::ID_W'(1);
					end
				end
				rrpt_pkg::OP_TICK: begin
					// Take one quantum from each used slot, drop slots that run out
					for (int i = 0; i < SLOTS; i++) begin
						if (used_q[i]) begin
							if (rem_q[i] > quant_w) begin
								rem_d[i] = rem_q[i] - quant_w;
							end else begin
								rem_d[i]  = '0;
								used_d[i] = 1'b0;
							end
						end
					end
				end
				rrpt_pkg::OP_KILL: begin
					used_d = used_q & ~kill_oh;
				end
				rrpt_pkg::OP_COUNT: begin
				end
				default: begin
				end
			endcase
		end
		res.active_count = '0;
		for (int i = 0; i < SLOTS; i++) begin
			res.active_count = res.active_count + rrpt_pkg::COUNT_W'(used_d[i]);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ctr_q  <= rrpt_pkg::ID_RESET;
		end else if (cmd.fire) begin
			used_q <= used_d;
			ctr_q  <= ctr_d;
		end
	end

	// Slot payload, guarded by the used flags
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			id_q  <= id_d;
			rem_q <= rem_d;
		end
	end

`ifndef SYNTHESIS
	a_add_advances_id: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && cmd.opcode == rrpt_pkg::OP_ADD && !full)
		|=> (ctr_q == $past(ctr_q) + rrpt_pkg::ID_W'(1)))
		else $error("id counter did not advance after a successful add");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && res.status) |-> (&used_q))
		else $error("full reported while a slot is free");

	a_kill_never_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && cmd.opcode == rrpt_pkg::OP_KILL)
		|=> ((used_q & ~$past(used_q)) == '0))
		else $error("kill marked a slot as used");

	a_tick_never_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && cmd.opcode == rrpt_pkg::OP_TICK)
		|=> ((used_q & ~$past(used_q)) == '0))
		else $error("tick marked a slot as used");
`endif

endmodule

// ----- sv/round_robin_process_table_top.sv -----
// Round-robin process table, top level. A result is registered after its command
// transfer and is then transferred from the output (input register, then result register).
// Throughput: one command per cycle, set by the combinational slot table update between
// the registers; the input stalls only while a result waits.
// Reset (arst_n, asynchronous): all slots free, id counter 1, time quantum 4.
// Depends on rrpt_pkg, rrpt_cfg and rrpt_table.
module round_robin_process_table_top #(
	parameter int unsigned SLOTS = rrpt_pkg::SLOTS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Command channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic signed [rrpt_pkg::WORK_W-1:0]  burst_in,
	input  logic [rrpt_pkg::ID_W-1:0]           kill_id,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rrpt_pkg::ID_W-1:0]           new_id,
	output logic                                status,
	output logic [rrpt_pkg::COUNT_W-1:0]        active_count,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rrpt_pkg::PADDR_W-1:0]        paddr,
	input  logic [rrpt_pkg::PDATA_W-1:0]        pwdata,
	output logic [rrpt_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	logic                          valid_s1;
	rrpt_pkg::op_t                 opcode_s1;
	logic [rrpt_pkg::WORK_W-1:0]   burst_s1;
	logic [rrpt_pkg::ID_W-1:0]     kill_id_s1;
	logic                          valid_s2;
	rrpt_pkg::res_t                res_s2;
	rrpt_pkg::res_t                res;
	rrpt_pkg::cmd_t                cmd;
	logic [rrpt_pkg::QUANT_W-1:0]  quantum;
	logic                          advance;

	rrpt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.quantum (quantum)
	);

	// Move a command into the table when the result register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign cmd.fire    = advance;
	assign cmd.opcode  = opcode_s1;
	assign cmd.burst   = burst_s1;
	assign cmd.kill_id = kill_id_s1;

	rrpt_table #(
		.SLOTS (SLOTS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.quantum (quantum),
		.res     (res)
	);

	// Input register: take a transfer, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1  <= rrpt_pkg::op_t'(opcode);
			burst_s1   <= burst_in;
			kill_id_s1 <= kill_id;
		end
	end

	// Result register: load on advance, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign new_id       = res_s2.new_id;
	assign status       = res_s2.status;
	assign active_count = res_s2.active_count;

`ifndef SYNTHESIS
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a blocked result");

	a_advance_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register not loaded after advance");

	a_held_command_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(opcode_s1) && $stable(kill_id_s1)))
		else $error("stalled command lost");
`endif

endmodule
